// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the clamped rmsd accumulator RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define CRA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define CRA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define CRA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CRA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/cra_pkg.sv -----
// ----------------------------------------------------------------------------
// cra_pkg
// Widths, constants and the queue entry type of the clamped rmsd accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package cra_pkg;

   // field widths
   localparam int COORD_W  = 21;
   localparam int MAG_W    = COORD_W + 1;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int SSQ_W    = SQ_W + 2;
   localparam int CUT_W    = 32;
   localparam int SUM_W    = 48;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int SREM_W   = ROOT_W + 2;
   localparam int RMSD_W   = 16;
   localparam int PAIRS_W  = 17;
   localparam int STEP_W   = $clog2(SUM_W);

   localparam logic [CUT_W-1:0] CUT_RESET = '1;
   localparam logic [SUM_W-1:0] SUM_MAX   = '1;

   // one classified pair on its way from front to back
   typedef struct packed {
      logic             counted;
      logic             last;
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic [MAG_W-1:0] mag_z;
   } cra_item_type;

endpackage

`default_nettype wire

// ----- src/cra_req_if.sv -----
// ----------------------------------------------------------------------------
// cra_req_if
// Input channel: one aligned point pair per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface cra_req_if;
   import cra_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      gap;
   logic signed [COORD_W-1:0] first_x;
   logic signed [COORD_W-1:0] first_y;
   logic signed [COORD_W-1:0] first_z;
   logic signed [COORD_W-1:0] second_x;
   logic signed [COORD_W-1:0] second_y;
   logic signed [COORD_W-1:0] second_z;
   logic                      last;

   modport source (output valid, gap, first_x, first_y, first_z,
                   second_x, second_y, second_z, last, input ready);
   modport sink   (input valid, gap, first_x, first_y, first_z,
                   second_x, second_y, second_z, last, output ready);
endinterface

`default_nettype wire

// ----- src/cra_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cra_rsp_if
// Result channel: one rmsd result per run
// ----------------------------------------------------------------------------
`default_nettype none

interface cra_rsp_if;
   import cra_pkg::*;

   logic                valid;
   logic                ready;
   logic [RMSD_W-1:0]   rmsd;
   logic [PAIRS_W-1:0]  pairs_used;
   logic                saturated;

   modport source (output valid, rmsd, pairs_used, saturated, input ready);
   modport sink   (input valid, rmsd, pairs_used, saturated, output ready);
endinterface

`default_nettype wire

// ----- src/clamped_rmsd_accumulator.sv -----
// ----------------------------------------------------------------------------
// clamped_rmsd_accumulator
// RMSD over a stream of aligned point pairs, each squared distance capped
// ----------------------------------------------------------------------------
//  channel   direction  transfer                 payload
//  req_ch    in         valid & ready            gap, first_xyz, second_xyz, last
//  rsp_ch    out        valid & ready            rmsd, pairs_used, saturated
//  csr_*     in         csr_wr_en (no wait)      cutoff_sq
//
//  One pair per cycle passes front, queue and the three-stage back pipeline,
//  unless a last item waits for the finisher. The finisher forms a run's
//  result by bit-serial divide and then square root, both skipped when no
//  pair was counted. A second last item waits at the accumulator until the
//  finisher has delivered; pairs behind it fill the queue and then stall req_ch.
//  Reset is synchronous, active high; cutoff_sq resets to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module clamped_rmsd_accumulator #(
   parameter int MAX_PAIRS   = 65536,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   cra_req_if.sink                        req_ch,
   cra_rsp_if.source                      rsp_ch,
   input  wire logic                      csr_wr_en,
   input  wire logic [cra_pkg::CUT_W-1:0] csr_wr_data
);
   import cra_pkg::*;
   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(MAX_PAIRS + 1);

   logic [CUT_W-1:0] cutoff_ff, cutoff_in;
   logic             fifo_push, fifo_pop, fifo_full, fifo_nempty;
   cra_item_type     push_item, pop_item;
   logic             fin_idle, fin_start, fin_ovf;
   logic [SUM_W-1:0] fin_sum;
   logic [CNT_W-1:0] fin_cnt;

   // cutoff register
   assign cutoff_in = csr_wr_en ? csr_wr_data : cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUT_RESET;
      end else begin
         cutoff_ff <= cutoff_in;
      end
   end

   cra_front u_front (
      .req       (req_ch),
      .fifo_full (fifo_full),
      .fifo_push (fifo_push),
      .fifo_item (push_item)
   );

   cra_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .wr_item (push_item),
      .full    (fifo_full),
      .pop     (fifo_pop),
      .rd_item (pop_item),
      .nempty  (fifo_nempty)
   );

   cra_back #(
      .MAX_PAIRS (MAX_PAIRS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_nempty (fifo_nempty),
      .fifo_item   (pop_item),
      .fifo_pop    (fifo_pop),
      .cutoff_sq   (cutoff_ff),
      .fin_idle    (fin_idle),
      .fin_start   (fin_start),
      .fin_sum     (fin_sum),
      .fin_cnt     (fin_cnt),
      .fin_ovf     (fin_ovf)
   );

   cra_finish #(
      .MAX_PAIRS (MAX_PAIRS)
   ) u_finish (
      .clock (clock),
      .reset (reset),
      .start (fin_start),
      .sum   (fin_sum),
      .cnt   (fin_cnt),
      .ovf   (fin_ovf),
      .idle  (fin_idle),
      .rsp   (rsp_ch)
   );

   // queue never overfills or underflows, finisher is taken only when free
   `CRA_ASSERT_IMPLY(a_no_push_when_full, clock, reset, fifo_full, !fifo_push)
   `CRA_ASSERT_IMPLY(a_pop_needs_data, clock, reset, fifo_pop, fifo_nempty)
   `CRA_ASSERT_IMPLY(a_start_when_idle, clock, reset, fin_start, fin_idle)
   `CRA_ASSERT_NEXT(a_busy_after_start, clock, reset, fin_start, !fin_idle)
endmodule

`default_nettype wire

// ----- src/cra_front.sv -----
// ----------------------------------------------------------------------------
// cra_front
// Accepts pairs, classifies gap and last, forms per-axis distance magnitudes
// ----------------------------------------------------------------------------
`default_nettype none

module cra_front (
   cra_req_if.sink              req,
   input  wire logic            fifo_full,
   output logic                 fifo_push,
   output cra_pkg::cra_item_type fifo_item
);
   import cra_pkg::*;

   function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
      logic [MAG_W-1:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
   endfunction

   // take a transfer whenever the queue has room
   assign req.ready = !fifo_full;
   assign fifo_push = req.valid && !fifo_full;

   // classify and reduce each axis to an unsigned magnitude
   always_comb begin
      fifo_item.counted = !req.gap;
      fifo_item.last    = req.last;
      fifo_item.mag_x   = abs_diff(req.first_x, req.second_x);
      fifo_item.mag_y   = abs_diff(req.first_y, req.second_y);
      fifo_item.mag_z   = abs_diff(req.first_z, req.second_z);
   end
endmodule

`default_nettype wire

// ----- src/cra_fifo.sv -----
// ----------------------------------------------------------------------------
// cra_fifo
// Short queue between front and back so each side stalls on its own
// ----------------------------------------------------------------------------
`default_nettype none

module cra_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire cra_pkg::cra_item_type wr_item,
   output logic                       full,
   input  wire logic                  pop,
   output cra_pkg::cra_item_type      rd_item,
   output logic                       nempty
);
   import cra_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cra_item_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_FULL);
   assign nempty  = (count_ff != '0);
   assign rd_item = entry_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end
endmodule

`default_nettype wire

// ----- src/cra_back.sv -----
// ----------------------------------------------------------------------------
// cra_back
// Squares, clamps and accumulates pairs; hands each finished run to the finisher
// ----------------------------------------------------------------------------
`default_nettype none

module cra_back #(
   parameter int MAX_PAIRS = 65536,
   localparam int CNT_W    = $clog2(MAX_PAIRS + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fifo_nempty,
   input  wire cra_pkg::cra_item_type      fifo_item,
   output logic                            fifo_pop,
   input  wire logic [cra_pkg::CUT_W-1:0]  cutoff_sq,
   input  wire logic                       fin_idle,
   output logic                            fin_start,
   output logic [cra_pkg::SUM_W-1:0]       fin_sum,
   output logic [CNT_W-1:0]                fin_cnt,
   output logic                            fin_ovf
);
   import cra_pkg::*;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAIRS);

   // square stage
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_counted_ff, s1_last_ff;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff, sqz_ff;
   // sum and clamp stage
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_counted_ff, s2_last_ff;
   logic [CUT_W-1:0] dd_ff, dd_in;
   logic [SSQ_W-1:0] ssq;
   // accumulators
   logic [SUM_W-1:0] sum_ff, sum_in, sum_nxt;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_nxt;
   logic             ovf_ff, ovf_in, ovf_nxt;
   logic [SUM_W:0]   sum_wide;
   logic             advance, fire;

   // a last item waits here until the finisher is free
   assign advance  = !(s2_valid_ff && s2_last_ff && !fin_idle);
   assign fifo_pop = fifo_nempty && advance;
   assign fire     = s2_valid_ff && advance;

   assign s1_valid_in = advance ? fifo_pop : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   // sum of squares capped at the cutoff
   always_comb begin
      ssq   = SSQ_W'(sqx_ff) + SSQ_W'(sqy_ff) + SSQ_W'(sqz_ff);
      dd_in = (ssq > SSQ_W'(cutoff_sq)) ? cutoff_sq : ssq[CUT_W-1:0];
   end

   // saturating accumulate of the item in the last stage
   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(dd_ff);
      sum_nxt  = sum_ff;
      cnt_nxt  = cnt_ff;
      ovf_nxt  = ovf_ff;
      if (s2_counted_ff) begin
         if (cnt_ff == CNT_MAX) begin
            ovf_nxt = 1'b1;
         end else begin
            cnt_nxt = cnt_ff + CNT_W'(1);
            if (sum_wide[SUM_W]) begin
               sum_nxt = SUM_MAX;
               ovf_nxt = 1'b1;
            end else begin
               sum_nxt = sum_wide[SUM_W-1:0];
            end
         end
      end
   end

   // run boundary: hand off and clear
   always_comb begin
      fin_start = fire && s2_last_ff;
      fin_sum   = sum_nxt;
      fin_cnt   = cnt_nxt;
      fin_ovf   = ovf_nxt;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      if (fire) begin
         if (s2_last_ff) begin
            sum_in = '0;
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            sum_in = sum_nxt;
            cnt_in = cnt_nxt;
            ovf_in = ovf_nxt;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         sum_ff      <= sum_in;
         cnt_ff      <= cnt_in;
         ovf_ff      <= ovf_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         s1_counted_ff <= fifo_item.counted;
         s1_last_ff    <= fifo_item.last;
         sqx_ff        <= SQ_W'(fifo_item.mag_x) * SQ_W'(fifo_item.mag_x);
         sqy_ff        <= SQ_W'(fifo_item.mag_y) * SQ_W'(fifo_item.mag_y);
         sqz_ff        <= SQ_W'(fifo_item.mag_z) * SQ_W'(fifo_item.mag_z);
      end
      if (advance) begin
         s2_counted_ff <= s1_counted_ff;
         s2_last_ff    <= s1_last_ff;
         dd_ff         <= dd_in;
      end
   end
endmodule

`default_nettype wire

// ----- src/cra_finish.sv -----
// ----------------------------------------------------------------------------
// cra_finish
// Bit-serial divide of sum by count, then digit-serial square root
// ----------------------------------------------------------------------------
`default_nettype none

module cra_finish #(
   parameter int MAX_PAIRS = 65536,
   localparam int CNT_W    = $clog2(MAX_PAIRS + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [cra_pkg::SUM_W-1:0]  sum,
   input  wire logic [CNT_W-1:0]           cnt,
   input  wire logic                       ovf,
   output logic                            idle,
   cra_rsp_if.source                       rsp
);
   import cra_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

   logic [1:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    num_ff, num_in;
   logic [CNT_W-1:0]    den_ff, den_in;
   logic [CNT_W:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SREM_W-1:0]   srem_ff, srem_in;
   logic [RMSD_W-1:0]   rmsd_ff, rmsd_in;
   logic [PAIRS_W-1:0]  pairs_ff, pairs_in;
   logic                ovf_ff, ovf_in;

   logic [CNT_W:0]             rem_sh;
   logic [SREM_W-1:0]          srem_sh, trial;
   logic [ROOT_W-1:0]          root_new;
   logic [CNT_W+PAIRS_W-1:0]   cnt_ext;

   assign idle       = (state_ff == ST_IDLE);
   assign rsp.valid  = (state_ff == ST_OUT);
   assign rsp.rmsd   = rmsd_ff;
   assign rsp.pairs_used = pairs_ff;
   assign rsp.saturated  = ovf_ff;

   // one quotient bit and one root digit per step
   always_comb begin
      cnt_ext  = {{PAIRS_W{1'b0}}, cnt};
      rem_sh   = {rem_ff[CNT_W-1:0], num_ff[SUM_W-1]};
      srem_sh  = {srem_ff[SREM_W-3:0], num_ff[SUM_W-1 -: 2]};
      trial    = {root_ff, 2'b01};
      root_new = {root_ff[ROOT_W-2:0], (srem_sh >= trial)};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      rmsd_in  = rmsd_ff;
      pairs_in = pairs_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pairs_in = cnt_ext[PAIRS_W-1:0];
               ovf_in   = ovf;
               num_in   = sum;
               den_in   = cnt;
               rem_in   = '0;
               step_in  = '0;
               if (cnt == '0) begin
                  rmsd_in  = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               num_in = {num_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               root_in  = '0;
               srem_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            srem_in = (srem_sh >= trial) ? srem_sh - trial : srem_sh;
            root_in = root_new;
            num_in  = {num_ff[SUM_W-3:0], 2'b00};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == SQRT_LAST) begin
               rmsd_in  = (|root_new[ROOT_W-1:RMSD_W]) ? '1 : root_new[RMSD_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      srem_ff  <= srem_in;
      rmsd_ff  <= rmsd_in;
      pairs_ff <= pairs_in;
      ovf_ff   <= ovf_in;
   end
endmodule

`default_nettype wire

// ----- dv/clamped_rmsd_accumulator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clamped_rmsd_accumulator_tb
// Streams aligned point pairs into the accumulator under random valid and
// ready gaps, predicts each run's clamped rmsd, pair count and saturation
// flag, and checks every result transfer in order against the prediction.
// ----------------------------------------------------------------------------

module clamped_rmsd_accumulator_tb;
   import cra_pkg::*;

   localparam int PAIR_LIMIT    = 65536;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 1500000;

   typedef logic signed [COORD_W-1:0] coord_type;

   // one alignment column as it crosses the input channel
   typedef struct {
      logic      gap;
      coord_type p [3];
      coord_type q [3];
      logic      last;
   } column_type;

   // one run summary as it crosses the result channel
   typedef struct {
      logic [RMSD_W-1:0]  rmsd;
      logic [PAIRS_W-1:0] pairs;
      logic               sat;
   } run_result_type;

   typedef enum int {RAW_BITS, SPAN, NEAR, CORNER} coord_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [CUT_W-1:0]    csr_wr_data = '0;

   cra_req_if req_ch ();
   cra_rsp_if rsp_ch ();

   clamped_rmsd_accumulator #(
      .MAX_PAIRS (PAIR_LIMIT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // stimulus and expectation stores
   column_type     columns_to_send [$];
   run_result_type runs_due [$];
   int unsigned    columns_queued = 0;
   int unsigned    columns_taken  = 0;
   int unsigned    error_count    = 0;
   int unsigned    cycle_count    = 0;
   int             send_idle_pct  = 0;
   int             recv_idle_pct  = 0;
   logic           req_taken      = 1'b0;
   column_type     next_column;

   // accumulator shadow state
   logic [CUT_W-1:0] cap_sq   = CUT_RESET;
   longint unsigned  acc_sum  = 0;
   int unsigned      acc_pairs = 0;
   logic             acc_sat  = 1'b0;

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // squared distance of one pair, exact
   function automatic longint unsigned dist_sq(input column_type c);
      longint unsigned total;
      longint          d;
      total = 0;
      for (int a = 0; a < 3; a++) begin
         d = longint'(c.p[a]) - longint'(c.q[a]);
         total += longint'(d * d);
      end
      return total;
   endfunction

   // floor square root, one root bit at a time from the top
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = ROOT_W; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch @%0t: %s", $realtime, msg);
   endfunction

   // fold one accepted column into the shadow run, emit a result on last
   task automatic fold_column(input column_type c);
      longint unsigned dd;
      longint unsigned root;
      run_result_type  r;
      if (!c.gap) begin
         if (acc_pairs >= PAIR_LIMIT) begin
            acc_sat = 1'b1;
         end else begin
            dd = dist_sq(c);
            if (dd > cap_sq) dd = cap_sq;
            if (dd > SUM_MAX - acc_sum) begin
               acc_sum = SUM_MAX;
               acc_sat = 1'b1;
            end else begin
               acc_sum += dd;
            end
            acc_pairs++;
         end
      end
      if (c.last) begin
         root = (acc_pairs == 0) ? 0 : floor_root(acc_sum / acc_pairs);
         if (root > 64'hFFFF) root = 64'hFFFF;
         r.rmsd  = root[RMSD_W-1:0];
         r.pairs = acc_pairs[PAIRS_W-1:0];
         r.sat   = acc_sat;
         runs_due.push_back(r);
         acc_sum   = 0;
         acc_pairs = 0;
         acc_sat   = 1'b0;
      end
   endtask

   function automatic column_type capture_column();
      column_type c;
      c.gap  = req_ch.gap;
      c.last = req_ch.last;
      c.p[0] = req_ch.first_x;
      c.p[1] = req_ch.first_y;
      c.p[2] = req_ch.first_z;
      c.q[0] = req_ch.second_x;
      c.q[1] = req_ch.second_y;
      c.q[2] = req_ch.second_z;
      return c;
   endfunction

   // compare one result transfer with the oldest prediction
   task automatic check_result();
      run_result_type want;
      if (runs_due.size() == 0) begin
         note_error($sformatf("unexpected result rmsd=%0d pairs=%0d sat=%0b",
                              rsp_ch.rmsd, rsp_ch.pairs_used, rsp_ch.saturated));
         return;
      end
      want = runs_due.pop_front();
      if (rsp_ch.rmsd !== want.rmsd)
         note_error($sformatf("rmsd exp %0d got %0d", want.rmsd, rsp_ch.rmsd));
      if (rsp_ch.pairs_used !== want.pairs)
         note_error($sformatf("pairs_used exp %0d got %0d", want.pairs,
                              rsp_ch.pairs_used));
      if (rsp_ch.saturated !== want.sat)
         note_error($sformatf("saturated exp %0b got %0b", want.sat,
                              rsp_ch.saturated));
   endtask

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      req_taken = !reset && req_ch.valid && req_ch.ready;
      if (req_taken) begin
         columns_taken++;
         fold_column(capture_column());
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_result();
   end

   // driver: present the next column and the result ready at the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (columns_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_column = columns_to_send.pop_front();
            req_ch.valid    <= 1'b1;
            req_ch.gap      <= next_column.gap;
            req_ch.last     <= next_column.last;
            req_ch.first_x  <= next_column.p[0];
            req_ch.first_y  <= next_column.p[1];
            req_ch.first_z  <= next_column.p[2];
            req_ch.second_x <= next_column.q[0];
            req_ch.second_y <= next_column.q[1];
            req_ch.second_z <= next_column.q[2];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // coordinate pickers
   function automatic coord_type span_coord();
      return coord_type'(int'($urandom_range(2000000)) - 1000000);
   endfunction

   function automatic coord_type corner_coord();
      case ($urandom_range(4))
         0:       return coord_type'(-1000000);
         1:       return coord_type'(1000000);
         2:       return coord_type'(0);
         3:       return coord_type'(-(1 << 20));
         default: return coord_type'((1 << 20) - 1);
      endcase
   endfunction

   function automatic column_type random_column(input logic gap, input logic last);
      column_type     c;
      coord_mode_type mode;
      mode   = coord_mode_type'($urandom_range(3));
      c.gap  = gap;
      c.last = last;
      for (int a = 0; a < 3; a++) begin
         case (mode)
            RAW_BITS: begin
               c.p[a] = coord_type'($urandom);
               c.q[a] = coord_type'($urandom);
            end
            SPAN: begin
               c.p[a] = span_coord();
               c.q[a] = span_coord();
            end
            NEAR: begin
               c.p[a] = span_coord();
               c.q[a] = c.p[a] + coord_type'(int'($urandom_range(4000)) - 2000);
            end
            default: begin
               c.p[a] = corner_coord();
               c.q[a] = corner_coord();
            end
         endcase
      end
      return c;
   endfunction

   function automatic column_type make_column(input logic gap, input int px, input int py,
                                              input int pz, input int qx, input int qy,
                                              input int qz, input logic last);
      column_type c;
      c.gap  = gap;
      c.last = last;
      c.p[0] = coord_type'(px);
      c.p[1] = coord_type'(py);
      c.p[2] = coord_type'(pz);
      c.q[0] = coord_type'(qx);
      c.q[1] = coord_type'(qy);
      c.q[2] = coord_type'(qz);
      return c;
   endfunction

   task automatic send_column(input column_type c);
      columns_to_send.push_back(c);
      columns_queued++;
   endtask

   // wait until every queued column is taken and every result is in
   task automatic settle();
      do @(negedge clock);
      while (columns_taken != columns_queued || runs_due.size() != 0);
   endtask

   // register write only while the block is idle
   task automatic load_cutoff(input logic [CUT_W-1:0] value);
      settle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cap_sq = value;
   endtask

   // random runs, each closed by a last column
   task automatic queue_random_runs(input int n_items);
      int made;
      int len;
      int shape;
      made = 0;
      while (made < n_items) begin
         shape = $urandom_range(99);
         if (shape < 8)       len = $urandom_range(1, 3);
         else if (shape < 22) len = 1;
         else                 len = $urandom_range(2, 16);
         for (int k = 0; k < len; k++)
            send_column(random_column(shape < 8 || $urandom_range(99) < 15,
                                      k == len - 1));
         made += len;
      end
   endtask

   // sequence
   initial begin
      req_ch.valid    = 1'b0;
      req_ch.gap      = 1'b0;
      req_ch.last     = 1'b0;
      req_ch.first_x  = '0;
      req_ch.first_y  = '0;
      req_ch.first_z  = '0;
      req_ch.second_x = '0;
      req_ch.second_y = '0;
      req_ch.second_z = '0;
      rsp_ch.ready    = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles less than receiver, then the other way round
      send_idle_pct = 33;
      recv_idle_pct = 57;

      load_cutoff(32'hFFFF_FFFF);
      // no pairs at all, gap carries last
      send_column(make_column(1'b1, 5, 6, 7, 8, 9, 10, 1'b1));
      // opposite corners of the legal cube, capped at the cutoff
      send_column(make_column(1'b0, -1000000, -1000000, -1000000,
                              1000000, 1000000, 1000000, 1'b1));
      // 3-4-5 triangle
      send_column(make_column(1'b0, 3, 4, 0, 0, 0, 0, 1'b1));
      // coordinates outside the legal range, gap mid-run, gap with last
      send_column(make_column(1'b0, -(1 << 20), (1 << 20) - 1, 0,
                              (1 << 20) - 1, -(1 << 20), 0, 1'b0));
      send_column(make_column(1'b1, 1000000, 0, 0, -1000000, 0, 0, 1'b0));
      send_column(make_column(1'b0, 1234, -5678, 42, 1234, -5678, 42, 1'b0));
      send_column(make_column(1'b1, 0, 0, 0, 999, 999, 999, 1'b1));
      // sender holds off mid-run until all results are back
      send_column(make_column(1'b0, 100, 200, 300, 110, 190, 305, 1'b0));
      send_column(make_column(1'b0, -7, 0, 7, 7, 0, -7, 1'b0));
      send_column(make_column(1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
      settle();
      send_column(make_column(1'b0, 500000, 500000, 500000, 0, 0, 0, 1'b0));
      send_column(make_column(1'b0, 1, 1, 1, 0, 0, 0, 1'b1));

      // zero cap: every pair counts, nothing adds
      load_cutoff(32'h0);
      send_column(make_column(1'b0, -1000000, 0, 1000000, 1000000, 0, -1000000, 1'b0));
      send_column(make_column(1'b0, 3, 4, 0, 0, 0, 0, 1'b1));

      // cap exactly at one pair's squared distance
      load_cutoff(32'd25);
      send_column(make_column(1'b0, 3, 4, 0, 0, 0, 0, 1'b0));
      send_column(make_column(1'b0, 9000, 0, 0, 0, 0, 0, 1'b1));

      load_cutoff($urandom);
      queue_random_runs(350);
      load_cutoff(32'd4000000);
      queue_random_runs(350);

      settle();
      send_idle_pct = 57;
      recv_idle_pct = 33;
      load_cutoff(32'd1);
      queue_random_runs(350);
      load_cutoff(32'hFFFF_FFFF);
      queue_random_runs(350);

      settle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_cutoff(32'd16000000);
      queue_random_runs(350);

      settle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
